// ===== sv/ocsvm_pkg.sv =====
// Shared constants, codes, tables and helpers of the one-class SVM scorer.
package ocsvm_pkg;

  localparam int MaxVectors  = 256;
  localparam int MaxFeatures = 16;
  localparam int VecAw       = $clog2(MaxVectors);
  localparam int FeatAw      = $clog2(MaxFeatures);
  localparam int VecCntW     = $clog2(MaxVectors + 1);
  localparam int FeatCntW    = $clog2(MaxFeatures + 1);

  // tanh divider: numerator, denominator and quotient widths
  localparam int DivNumW = 34;
  localparam int DivDenW = 18;
  localparam int DivQW   = 17;
  localparam int DivCntW = $clog2(DivNumW);

  typedef enum logic [1:0] {
    CMD_LOAD_VEC  = 2'd0,
    CMD_LOAD_COEF = 2'd1,
    CMD_SAMPLE    = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    KERN_LINEAR  = 2'd0,
    KERN_RBF     = 2'd1,
    KERN_POLY    = 2'd2,
    KERN_SIGMOID = 2'd3
  } kern_t;

  typedef enum logic [2:0] {
    REG_KERNEL_KIND   = 3'd0,
    REG_GAMMA_SCALE   = 3'd1,
    REG_OFFSET_TERM   = 3'd2,
    REG_POLY_DEGREE   = 3'd3,
    REG_BIAS_RHO      = 3'd4,
    REG_VECTOR_COUNT  = 3'd5,
    REG_FEATURE_COUNT = 3'd6
  } reg_idx_t;

  // round(65536 * e^-k)
  function automatic logic [16:0] exp_int(input logic [3:0] k);
    logic [16:0] r;
    case (k)
      4'd0:    r = 17'd65536;
      4'd1:    r = 17'd24109;
      4'd2:    r = 17'd8869;
      4'd3:    r = 17'd3263;
      4'd4:    r = 17'd1200;
      4'd5:    r = 17'd442;
      4'd6:    r = 17'd162;
      4'd7:    r = 17'd60;
      4'd8:    r = 17'd22;
      4'd9:    r = 17'd8;
      4'd10:   r = 17'd3;
      4'd11:   r = 17'd1;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

  // round(65536 * e^-(i/8))
  function automatic logic [16:0] exp_frac(input logic [3:0] i);
    logic [16:0] r;
    case (i)
      4'd0:    r = 17'd65536;
      4'd1:    r = 17'd57835;
      4'd2:    r = 17'd51039;
      4'd3:    r = 17'd45042;
      4'd4:    r = 17'd39750;
      4'd5:    r = 17'd35079;
      4'd6:    r = 17'd30957;
      4'd7:    r = 17'd27319;
      4'd8:    r = 17'd24109;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== sv/one_class_svm_scorer_unit.sv =====
// One-class SVM decision scorer: model stores, shared multiplier and sequencer.
// Load items (support-vector elements, coefficients) and sample features that do not end a
// sample are stored as they are accepted. A sample item flagged as the last feature starts a
// score that walks every configured support vector with a single shared 33x33 multiplier:
// per vector a dot product (squared distance for RBF) over the features, the kernel, and the
// coefficient product into the sum; a bit-serial divider forms tanh for sigmoid. With no
// vectors configured the score is flagged not trained. The input is not ready while a score
// runs; a finished score waits in the output register.
module one_class_svm_scorer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // vector_slot[7:0], feature_slot[11:8], item_value[27:12]
  input  logic [1:0]  s_tuser,   // cmd
  input  logic        s_tlast,   // last_feature
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // score
  output logic [1:0]  m_tuser,   // inlier[0], not_trained[1]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE, S_FEAT, S_WAIT, S_KER, S_GM0, S_GM1, S_GMR, S_E1, S_E2, S_E3,
    S_EXPD, S_DIVW, S_P0, S_P1, S_COEF, S_ACC, S_SCORE, S_OUT
  } state_t;

  localparam int VecAw    = ocsvm_pkg::VecAw;
  localparam int FeatAw   = ocsvm_pkg::FeatAw;
  localparam int VecCntW  = ocsvm_pkg::VecCntW;
  localparam int FeatCntW = ocsvm_pkg::FeatCntW;

  // configuration registers
  logic [1:0]         kernel_kind;
  logic [15:0]        gamma_scale;
  logic [15:0]        offset_term;
  logic [3:0]         poly_degree;
  logic [31:0]        bias_rho;
  logic [8:0]         vector_count;
  logic [4:0]         feature_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_kind   <= 2'd0;
      gamma_scale   <= 16'd4096;
      offset_term   <= 16'd0;
      poly_degree   <= 4'd3;
      bias_rho      <= 32'd0;
      vector_count  <= 9'd0;
      feature_count <= 5'd16;
    end else if (cfg_we) begin
      case (ocsvm_pkg::reg_idx_t'(cfg_index))
        ocsvm_pkg::REG_KERNEL_KIND:   kernel_kind   <= cfg_data[1:0];
        ocsvm_pkg::REG_GAMMA_SCALE:   gamma_scale   <= cfg_data[15:0];
        ocsvm_pkg::REG_OFFSET_TERM:   offset_term   <= cfg_data[15:0];
        ocsvm_pkg::REG_POLY_DEGREE:   poly_degree   <= cfg_data[3:0];
        ocsvm_pkg::REG_BIAS_RHO:      bias_rho      <= cfg_data;
        ocsvm_pkg::REG_VECTOR_COUNT:  vector_count  <= cfg_data[8:0];
        ocsvm_pkg::REG_FEATURE_COUNT: feature_count <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // clamp counts to store sizes
  logic [VecCntW-1:0]  nv;
  logic [FeatCntW-1:0] nf;
  always_comb begin
    nv = (vector_count > 9'(ocsvm_pkg::MaxVectors)) ? VecCntW'(ocsvm_pkg::MaxVectors)
                                                   : VecCntW'(vector_count);
    nf = (feature_count > 5'(ocsvm_pkg::MaxFeatures)) ? FeatCntW'(ocsvm_pkg::MaxFeatures)
                                                     : FeatCntW'(feature_count);
  end

  // input fields
  logic [7:0]  in_vslot;
  logic [3:0]  in_fslot;
  logic [15:0] in_value;
  logic        s_xfer;
  assign in_vslot = s_tdata[7:0];
  assign in_fslot = s_tdata[11:8];
  assign in_value = s_tdata[27:12];
  assign s_xfer   = s_tvalid & s_tready;

  state_t state;
  logic [VecCntW-1:0]  v;
  logic [FeatCntW-1:0] f;

  // model stores, registered reads
  logic [15:0] vec_mem [ocsvm_pkg::MaxVectors*ocsvm_pkg::MaxFeatures];
  logic [15:0] coef_mem [ocsvm_pkg::MaxVectors];
  logic [15:0] samp_mem [ocsvm_pkg::MaxFeatures];
  logic [15:0] vec_q, coef_q, samp_q;

  always_ff @(posedge clk) begin
    if (s_xfer && ocsvm_pkg::cmd_t'(s_tuser) == ocsvm_pkg::CMD_LOAD_VEC)
      vec_mem[{in_vslot[VecAw-1:0], in_fslot[FeatAw-1:0]}] <= in_value;
    vec_q <= vec_mem[{v[VecAw-1:0], f[FeatAw-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (s_xfer && ocsvm_pkg::cmd_t'(s_tuser) == ocsvm_pkg::CMD_LOAD_COEF)
      coef_mem[in_vslot[VecAw-1:0]] <= in_value;
    coef_q <= coef_mem[v[VecAw-1:0]];
  end

  always_ff @(posedge clk) begin
    if (s_xfer && ocsvm_pkg::cmd_t'(s_tuser) == ocsvm_pkg::CMD_SAMPLE)
      samp_mem[in_fslot[FeatAw-1:0]] <= in_value;
    samp_q <= samp_mem[f[FeatAw-1:0]];
  end

  // datapath registers
  logic               mac_pend;
  logic signed [39:0] dacc;
  logic signed [63:0] macc;
  logic signed [63:0] sum;
  logic [39:0]        earg;
  logic               neg;
  logic signed [31:0] pval, parg, kval;
  logic [3:0]         dcnt;
  logic [16:0]        ev;
  logic [31:0]        res_score;
  logic               res_inlier, res_nt;

  // divider hookup
  logic                              div_start, div_done;
  logic [ocsvm_pkg::DivNumW-1:0]     div_num;
  logic [ocsvm_pkg::DivDenW-1:0]     div_den;
  logic [ocsvm_pkg::DivQW-1:0]       div_quot;

  ocsvm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // shared multiplier and its operand select
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic signed [16:0] df;
  logic [16:0]        ef;
  logic [16:0]        fr_lo, fr_hi;

  always_comb begin
    df    = {samp_q[15], samp_q} - {vec_q[15], vec_q};
    fr_lo = ocsvm_pkg::exp_frac({1'b0, earg[15:13]});
    fr_hi = ocsvm_pkg::exp_frac({1'b0, earg[15:13]} + 4'd1);
    ef    = fr_lo - 17'((macc[28:0] + 29'd4096) >> 13);
    mul_a = '0;
    mul_b = '0;
    if (mac_pend) begin
      if (ocsvm_pkg::kern_t'(kernel_kind) == ocsvm_pkg::KERN_RBF) begin
        mul_a = {{16{df[16]}}, df};
        mul_b = {{16{df[16]}}, df};
      end else begin
        mul_a = {{17{samp_q[15]}}, samp_q};
        mul_b = {{17{vec_q[15]}}, vec_q};
      end
    end else begin
      case (state)
        S_GM0: begin
          mul_a = {17'd0, gamma_scale};
          mul_b = {15'd0, dacc[17:0]};
        end
        S_GM1: begin
          mul_a = {17'd0, gamma_scale};
          mul_b = {{11{dacc[39]}}, dacc[39:18]};
        end
        S_E1: begin
          mul_a = {16'd0, fr_lo - fr_hi};
          mul_b = {20'd0, earg[12:0]};
        end
        S_E2: begin
          mul_a = {16'd0, ocsvm_pkg::exp_int(earg[19:16])};
          mul_b = {16'd0, ef};
        end
        S_P0: begin
          mul_a = {pval[31], pval};
          mul_b = {parg[31], parg};
        end
        S_COEF: begin
          mul_a = {{17{coef_q[15]}}, coef_q};
          mul_b = {kval[31], kval};
        end
        default: ;
      endcase
    end
    mul_p = mul_a * mul_b;
  end

  // gamma product rounding and kernel argument
  logic signed [63:0] gm_round;
  logic signed [39:0] argv, magv;
  always_comb begin
    gm_round = macc + 64'sd32768;
    argv     = $signed(gm_round[55:16]) + {{16{offset_term[15]}}, offset_term, 8'd0};
    magv     = argv[39] ? -argv : argv;
  end

  // polynomial step rounding
  logic signed [63:0] p_shift;
  logic signed [31:0] p_next;
  always_comb begin
    p_shift = (macc + 64'sd32768) >>> 16;
    p_next  = ocsvm_pkg::sat32(p_shift);
  end

  // tanh division operands
  logic [17:0] den_v;
  always_comb begin
    den_v = 18'd65536 + {1'b0, ev};
  end

  // final score
  logic signed [63:0] sum_rs, score_w;
  logic signed [31:0] score_s;
  always_comb begin
    sum_rs  = (sum + 64'sd128) >>> 8;
    score_w = sum_rs - {{32{bias_rho[31]}}, bias_rho};
    score_s = ocsvm_pkg::sat32(score_w);
  end

  assign s_tready = (state == S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mac_pend  <= 1'b0;
      div_start <= 1'b0;
      m_tvalid  <= 1'b0;
      v         <= '0;
      f         <= '0;
    end else begin
      mac_pend  <= (state == S_FEAT);
      if (m_tvalid && m_tready && state != S_OUT) m_tvalid <= 1'b0;
      if (mac_pend) dacc <= dacc + mul_p[39:0];

      case (state)
        S_IDLE: begin
          if (s_xfer && s_tlast && ocsvm_pkg::cmd_t'(s_tuser) == ocsvm_pkg::CMD_SAMPLE) begin
            if (nv == '0) begin
              res_score  <= 32'd0;
              res_inlier <= 1'b0;
              res_nt     <= 1'b1;
              state      <= S_OUT;
            end else begin
              v     <= '0;
              f     <= '0;
              sum   <= '0;
              dacc  <= '0;
              state <= (nf == '0) ? S_KER : S_FEAT;
            end
          end
        end

        // stream features through the multiply-accumulate
        S_FEAT: begin
          f <= f + 1'b1;
          if (f == nf - 1'b1) state <= S_WAIT;
        end

        S_WAIT: state <= S_KER;

        S_KER: begin
          if (ocsvm_pkg::kern_t'(kernel_kind) == ocsvm_pkg::KERN_LINEAR) begin
            kval  <= ocsvm_pkg::sat32({{24{dacc[39]}}, dacc});
            state <= S_COEF;
          end else begin
            state <= S_GM0;
          end
        end

        // gamma times dot or norm, two partial products
        S_GM0: begin
          macc  <= mul_p[63:0];
          state <= S_GM1;
        end

        S_GM1: begin
          macc  <= macc + {mul_p[45:0], 18'd0};
          state <= S_GMR;
        end

        S_GMR: begin
          case (ocsvm_pkg::kern_t'(kernel_kind))
            ocsvm_pkg::KERN_RBF: begin
              earg  <= gm_round[55:16];
              state <= S_E1;
            end
            ocsvm_pkg::KERN_POLY: begin
              parg <= ocsvm_pkg::sat32({{24{argv[39]}}, argv});
              pval <= 32'sd65536;
              dcnt <= 4'd0;
              if (poly_degree == 4'd0) begin
                kval  <= 32'sd65536;
                state <= S_COEF;
              end else begin
                state <= S_P0;
              end
            end
            default: begin
              neg <= argv[39];
              if (magv >= 40'sd1048576) begin
                ev    <= 17'd0;
                state <= S_EXPD;
              end else begin
                earg  <= {magv[38:0], 1'b0};
                state <= S_E1;
              end
            end
          endcase
        end

        // exp(-a): integer part table times interpolated fraction table
        S_E1: begin
          if (earg[39:16] >= 24'd12) begin
            ev    <= 17'd0;
            state <= S_EXPD;
          end else begin
            macc  <= mul_p[63:0];
            state <= S_E2;
          end
        end

        S_E2: begin
          macc  <= mul_p[63:0];
          state <= S_E3;
        end

        S_E3: begin
          ev    <= 17'((macc[33:0] + 34'd32768) >> 16);
          state <= S_EXPD;
        end

        S_EXPD: begin
          if (ocsvm_pkg::kern_t'(kernel_kind) == ocsvm_pkg::KERN_RBF) begin
            kval  <= {15'd0, ev};
            state <= S_COEF;
          end else begin
            div_num   <= {1'b0, 17'd65536 - ev, 16'd0} + {16'd0, den_v >> 1};
            div_den   <= den_v;
            div_start <= 1'b1;
            state     <= S_DIVW;
          end
        end

        // start pulse lasts one cycle, then wait for the quotient
        S_DIVW: begin
          div_start <= 1'b0;
          if (div_done) begin
            kval  <= neg ? -{15'd0, div_quot} : {15'd0, div_quot};
            state <= S_COEF;
          end
        end

        // polynomial power, one product and rounding per degree
        S_P0: begin
          macc  <= mul_p[63:0];
          state <= S_P1;
        end

        S_P1: begin
          pval <= p_next;
          dcnt <= dcnt + 4'd1;
          if (dcnt + 4'd1 == poly_degree) begin
            kval  <= p_next;
            state <= S_COEF;
          end else begin
            state <= S_P0;
          end
        end

        S_COEF: begin
          macc  <= mul_p[63:0];
          state <= S_ACC;
        end

        // add into decision sum, move to next vector
        S_ACC: begin
          sum <= sum + macc;
          v   <= v + 1'b1;
          if (v + 1'b1 == nv) begin
            state <= S_SCORE;
          end else begin
            f     <= '0;
            dacc  <= '0;
            state <= (nf == '0) ? S_KER : S_FEAT;
          end
        end

        S_SCORE: begin
          res_score  <= score_s;
          res_inlier <= ~score_s[31];
          res_nt     <= 1'b0;
          state      <= S_OUT;
        end

        // hand over once the output register is free
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= res_score;
            m_tuser  <= {res_nt, res_inlier};
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/ocsvm_div.sv =====
// Restoring shift-subtract divider, one quotient bit per cycle.
module ocsvm_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [ocsvm_pkg::DivNumW-1:0]   num,
  input  logic [ocsvm_pkg::DivDenW-1:0]   den,
  output logic                            done,
  output logic [ocsvm_pkg::DivQW-1:0]     quot
);

  logic                            busy;
  logic [ocsvm_pkg::DivCntW-1:0]   cnt;
  logic [ocsvm_pkg::DivDenW:0]     rem;
  logic [ocsvm_pkg::DivNumW-1:0]   nreg;
  logic [ocsvm_pkg::DivDenW:0]     shifted;
  logic [ocsvm_pkg::DivDenW+1:0]   diff;
  logic                            ge;

  // trial subtract of the divisor from the shifted remainder
  always_comb begin
    shifted = {rem[ocsvm_pkg::DivDenW-1:0], nreg[ocsvm_pkg::DivNumW-1]};
    diff    = {1'b0, shifted} - {2'b00, den};
    ge      = ~diff[ocsvm_pkg::DivDenW+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        nreg <= num;
      end else if (busy) begin
        rem  <= ge ? diff[ocsvm_pkg::DivDenW:0] : shifted;
        nreg <= {nreg[ocsvm_pkg::DivNumW-2:0], ge};
        cnt  <= cnt + 1'b1;
        if (cnt == ocsvm_pkg::DivCntW'(ocsvm_pkg::DivNumW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient bits have shifted in from the bottom
  assign quot = nreg[ocsvm_pkg::DivQW-1:0];

endmodule

// ===== tb/one_class_svm_scorer_unit_test.sv =====
// Self-checking testbench for the one-class SVM scorer: streamed loads, samples and scores.
`timescale 1ns / 1ps

module one_class_svm_scorer_unit_test;

  typedef struct {
    logic [1:0]         cmd;
    logic [7:0]         vec_slot;
    logic [3:0]         feat_slot;
    logic signed [15:0] value;
    logic               last;
  } svm_item_t;

  typedef struct {
    logic signed [31:0] score;
    logic               inlier;
    logic               not_trained;
  } score_t;

  // command code the block ignores
  localparam logic [1:0] CmdIgnored = 2'd3;
  // vectors filled at start; larger counts are only used with empty vectors
  localparam int LoadedVectors = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // vector_slot[7:0], feature_slot[11:8], item_value[27:12]
  logic [1:0]  s_tuser = '0;   // cmd
  logic        s_tlast = 1'b0; // last_feature
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // score
  logic [1:0]  m_tuser;        // inlier[0], not_trained[1]
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  one_class_svm_scorer_unit u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirror of the block's state and registers
  logic signed [15:0] sv_mem [ocsvm_pkg::MaxVectors][ocsvm_pkg::MaxFeatures];
  logic signed [15:0] coef_mem [ocsvm_pkg::MaxVectors];
  logic signed [15:0] sample_mem [ocsvm_pkg::MaxFeatures];
  ocsvm_pkg::kern_t   kern_cfg;
  longint             gamma_cfg, offset_cfg, degree_cfg, rho_cfg, nvec_cfg, nfeat_cfg;

  longint unsigned exp_int_lut [12] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60, 22,
                                        8, 3, 1};
  longint unsigned exp_frac_lut [9] = '{65536, 57835, 51039, 45042, 39750, 35079, 30957,
                                        27319, 24109};

  svm_item_t item_queue [$];
  score_t    expected_scores [$];
  svm_item_t cur_item;
  bit        took = 1'b0;
  bit        hold_off = 1'b0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        error_count = 0;

  function automatic longint clip_q31(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint round_q(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  // e^-a, a in Q16.16, via integer and eighth-step tables with interpolation
  function automatic longint unsigned exp_neg_q16(longint unsigned a);
    longint unsigned k, f, i, low, ef;
    k = a >> 16;
    if (k >= 12) return 0;
    f = a & 16'hFFFF;
    i = f >> 13;
    low = f & 13'h1FFF;
    ef = exp_frac_lut[i] - (((exp_frac_lut[i] - exp_frac_lut[i + 1]) * low + 4096) >> 13);
    return (exp_int_lut[k] * ef + 32768) >> 16;
  endfunction

  function automatic longint tanh_q16(longint z);
    longint unsigned mag, e, den;
    longint t;
    mag = (z < 0) ? -z : z;
    e = (mag >= (64'd16 << 16)) ? 0 : exp_neg_q16(2 * mag);
    den = 65536 + e;
    t = longint'((((65536 - e) << 16) + den / 2) / den);
    return (z < 0) ? -t : t;
  endfunction

  function automatic longint kernel_of(int v, int nf);
    longint dot, arg, p, x, y, df;
    longint unsigned norm;
    dot = 0;
    norm = 0;
    for (int f = 0; f < nf; f++) begin
      x = sample_mem[f];
      y = sv_mem[v][f];
      df = x - y;
      dot += x * y;
      norm += longint'(df * df);
    end
    case (kern_cfg)
      ocsvm_pkg::KERN_LINEAR: return clip_q31(dot);
      ocsvm_pkg::KERN_RBF:
        return longint'(exp_neg_q16((longint'(gamma_cfg) * norm + 32768) >> 16));
      default: begin
        arg = round_q(gamma_cfg * dot, 16) + offset_cfg * 256;
        if (kern_cfg == ocsvm_pkg::KERN_SIGMOID) return tanh_q16(arg);
        arg = clip_q31(arg);
        p = 65536;
        for (int d = 0; d < degree_cfg; d++) p = clip_q31(round_q(p * arg, 16));
        return p;
      end
    endcase
  endfunction

  // Update the mirror for one accepted transfer and queue any score it causes
  function automatic void predict_transfer(svm_item_t it);
    int nv, nf;
    longint sum, sc;
    score_t r;
    case (it.cmd)
      ocsvm_pkg::CMD_LOAD_VEC:  sv_mem[it.vec_slot][it.feat_slot] = it.value;
      ocsvm_pkg::CMD_LOAD_COEF: coef_mem[it.vec_slot] = it.value;
      ocsvm_pkg::CMD_SAMPLE: begin
        sample_mem[it.feat_slot] = it.value;
        if (it.last) begin
          nv = (nvec_cfg > ocsvm_pkg::MaxVectors) ? ocsvm_pkg::MaxVectors : int'(nvec_cfg);
          nf = (nfeat_cfg > ocsvm_pkg::MaxFeatures) ? ocsvm_pkg::MaxFeatures
                                                    : int'(nfeat_cfg);
          if (nv == 0) begin
            r = '{score: 0, inlier: 1'b0, not_trained: 1'b1};
          end else begin
            sum = 0;
            for (int v = 0; v < nv; v++) sum += longint'(coef_mem[v]) * kernel_of(v, nf);
            sc = clip_q31(round_q(sum, 8) - rho_cfg);
            r = '{score: sc[31:0], inlier: (sc >= 0), not_trained: 1'b0};
          end
          expected_scores = {expected_scores, r};
        end
      end
      default: ;
    endcase
  endfunction

  // Input side: record transfers at the rising edge
  always @(posedge clk) begin
    took = !rst && s_tvalid && s_tready;
    if (took) predict_transfer(cur_item);
  end

  // Input side: present the next item at the falling edge
  always @(negedge clk) begin
    if (!s_tvalid || took) begin
      if (!rst && item_queue.size() > 0 && !hold_off &&
          $urandom_range(99) >= send_idle_pct) begin
        cur_item = item_queue.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, cur_item.value, cur_item.feat_slot, cur_item.vec_slot};
        s_tuser  <= cur_item.cmd;
        s_tlast  <= cur_item.last;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    took = 1'b0;
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Output side: compare each score transfer with the oldest expectation
  always @(posedge clk) begin
    score_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_scores.size() == 0) begin
        $error("unexpected score transfer: score %0d", $signed(m_tdata));
        error_count++;
      end else begin
        e = expected_scores.pop_front();
        if (m_tdata !== e.score) begin
          $error("score: expected %0d, actual %0d", e.score, $signed(m_tdata));
          error_count++;
        end
        if (m_tuser[0] !== e.inlier) begin
          $error("inlier: expected %0d, actual %0d", e.inlier, m_tuser[0]);
          error_count++;
        end
        if (m_tuser[1] !== e.not_trained) begin
          $error("not_trained: expected %0d, actual %0d", e.not_trained, m_tuser[1]);
          error_count++;
        end
      end
    end
  end

  function automatic logic signed [15:0] rand_value();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(511)) - 256);
      2: case ($urandom_range(2))
           0: return 16'sh7FFF;
           1: return 16'sh8000;
           default: return 16'sh0000;
         endcase
      default: return 16'($signed($urandom_range(4095)) - 2048);
    endcase
  endfunction

  task automatic queue_item(logic [1:0] c, logic [7:0] vs, logic [3:0] fs,
                            logic signed [15:0] val, logic lst);
    svm_item_t it;
    it = '{cmd: c, vec_slot: vs, feat_slot: fs, value: val, last: lst};
    item_queue = {item_queue, it};
  endtask

  task automatic queue_score(logic signed [15:0] val);
    queue_item(ocsvm_pkg::CMD_SAMPLE, 8'($urandom), 4'($urandom), val, 1'b1);
  endtask

  // Block is idle once everything is sent and scored
  task automatic wait_idle();
    while (item_queue.size() > 0 || s_tvalid || expected_scores.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(ocsvm_pkg::reg_idx_t idx, logic [31:0] val);
    wait_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      ocsvm_pkg::REG_KERNEL_KIND:   kern_cfg = ocsvm_pkg::kern_t'(val[1:0]);
      ocsvm_pkg::REG_GAMMA_SCALE:   gamma_cfg = val[15:0];
      ocsvm_pkg::REG_OFFSET_TERM:   offset_cfg = $signed(val[15:0]);
      ocsvm_pkg::REG_POLY_DEGREE:   degree_cfg = val[3:0];
      ocsvm_pkg::REG_BIAS_RHO:      rho_cfg = $signed(val[31:0]);
      ocsvm_pkg::REG_VECTOR_COUNT:  nvec_cfg = val[8:0];
      ocsvm_pkg::REG_FEATURE_COUNT: nfeat_cfg = val[4:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_config();
    int nvec;
    write_reg(ocsvm_pkg::REG_KERNEL_KIND, $urandom_range(3));
    write_reg(ocsvm_pkg::REG_GAMMA_SCALE,
              $urandom_range(1) ? $urandom_range(65535) : $urandom_range(8192));
    write_reg(ocsvm_pkg::REG_OFFSET_TERM,
              $urandom_range(1) ? $urandom : $urandom_range(511) - 256);
    write_reg(ocsvm_pkg::REG_POLY_DEGREE, $urandom_range(15));
    write_reg(ocsvm_pkg::REG_BIAS_RHO,
              $urandom_range(1) ? $urandom : $urandom_range(1 << 20) - (1 << 19));
    // big vector counts are slow, so keep them rare; their vectors stay empty
    nvec = ($urandom_range(19) == 0) ? $urandom_range(511) : $urandom_range(LoadedVectors);
    write_reg(ocsvm_pkg::REG_VECTOR_COUNT, nvec);
    write_reg(ocsvm_pkg::REG_FEATURE_COUNT, (nvec > LoadedVectors) ? 0 : $urandom_range(31));
  endtask

  // Mostly complete samples with random content, plus loads, stray features and noise
  task automatic random_block(int n, ref int counted);
    int got, len, r;
    got = 0;
    while (got < n) begin
      r = $urandom_range(99);
      if (r < 60) begin
        len = $urandom_range(1, 6);
        for (int j = 0; j < len; j++)
          queue_item(ocsvm_pkg::CMD_SAMPLE, 8'($urandom), 4'($urandom), rand_value(),
                     j == len - 1);
        got += len;
      end else if (r < 75) begin
        queue_item(ocsvm_pkg::CMD_LOAD_VEC, 8'($urandom), 4'($urandom), rand_value(),
                   1'($urandom));
        got++;
      end else if (r < 85) begin
        queue_item(ocsvm_pkg::CMD_LOAD_COEF, 8'($urandom), 4'($urandom), rand_value(),
                   1'($urandom));
        got++;
      end else if (r < 93) begin
        queue_item(ocsvm_pkg::CMD_SAMPLE, 8'($urandom), 4'($urandom), rand_value(), 1'b0);
        got++;
      end else begin
        queue_item(CmdIgnored, 8'($urandom), 4'($urandom), 16'($urandom), 1'($urandom));
      end
    end
    counted += got;
  endtask

  initial begin
    int counted;
    bit pressed;
    kern_cfg   = ocsvm_pkg::KERN_LINEAR;
    gamma_cfg  = 4096;
    offset_cfg = 0;
    degree_cfg = 3;
    rho_cfg    = 0;
    nvec_cfg   = 0;
    nfeat_cfg  = 16;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 6;
    recv_idle_pct = 65;

    // Fill all coefficients, the first vectors and the sample buffer; scores only ever
    // read these
    for (int v = 0; v < ocsvm_pkg::MaxVectors; v++) begin
      if (v < LoadedVectors) begin
        for (int f = 0; f < ocsvm_pkg::MaxFeatures; f++)
          queue_item(ocsvm_pkg::CMD_LOAD_VEC, 8'(v), 4'(f), rand_value(), 1'b0);
      end
      queue_item(ocsvm_pkg::CMD_LOAD_COEF, 8'(v), 4'(0), rand_value(), 1'b0);
    end
    for (int f = 0; f < ocsvm_pkg::MaxFeatures; f++)
      queue_item(ocsvm_pkg::CMD_SAMPLE, 8'(0), 4'(f), rand_value(), 1'b0);

    // Not trained after reset
    queue_score(16'sh7FFF);
    // every kernel over a few vectors
    write_reg(ocsvm_pkg::REG_VECTOR_COUNT, 4);
    for (int k = 0; k < 4; k++) begin
      write_reg(ocsvm_pkg::REG_KERNEL_KIND, k);
      queue_score(16'sh8000);
      queue_score(16'sh7FFF);
    end
    // ignored command and flags on loads
    queue_item(CmdIgnored, 8'hFF, 4'hF, 16'hFFFF, 1'b1);
    queue_item(ocsvm_pkg::CMD_LOAD_VEC, 8'd1, 4'd2, 16'sh0100, 1'b1);
    queue_item(ocsvm_pkg::CMD_LOAD_COEF, 8'd1, 4'd0, 16'sh8000, 1'b1);
    // empty vectors and zero degree
    write_reg(ocsvm_pkg::REG_KERNEL_KIND, 32'(ocsvm_pkg::KERN_POLY));
    write_reg(ocsvm_pkg::REG_POLY_DEGREE, 0);
    write_reg(ocsvm_pkg::REG_FEATURE_COUNT, 0);
    queue_score(16'sh0000);
    write_reg(ocsvm_pkg::REG_POLY_DEGREE, 8);
    write_reg(ocsvm_pkg::REG_OFFSET_TERM, 32'hFFFF8000);
    queue_score(16'sh7FFF);
    // vector count over the limit with empty vectors, rho extremes
    write_reg(ocsvm_pkg::REG_KERNEL_KIND, 32'(ocsvm_pkg::KERN_LINEAR));
    write_reg(ocsvm_pkg::REG_VECTOR_COUNT, 300);
    write_reg(ocsvm_pkg::REG_BIAS_RHO, 32'h7FFFFFFF);
    queue_score(16'sh8000);
    write_reg(ocsvm_pkg::REG_BIAS_RHO, 32'h80000000);
    queue_score(16'sh7FFF);
    // feature count over the limit
    write_reg(ocsvm_pkg::REG_BIAS_RHO, 0);
    write_reg(ocsvm_pkg::REG_VECTOR_COUNT, LoadedVectors);
    write_reg(ocsvm_pkg::REG_FEATURE_COUNT, 31);
    queue_score(16'sh4000);
    // gamma extremes
    write_reg(ocsvm_pkg::REG_FEATURE_COUNT, 16);
    write_reg(ocsvm_pkg::REG_KERNEL_KIND, 32'(ocsvm_pkg::KERN_RBF));
    write_reg(ocsvm_pkg::REG_GAMMA_SCALE, 0);
    queue_score(16'sh1234);
    write_reg(ocsvm_pkg::REG_KERNEL_KIND, 32'(ocsvm_pkg::KERN_SIGMOID));
    write_reg(ocsvm_pkg::REG_GAMMA_SCALE, 65535);
    write_reg(ocsvm_pkg::REG_OFFSET_TERM, 32'h7FFF);
    queue_score(16'shEDCB);

    // Random phases with three idling patterns
    for (int m = 0; m < 3; m++) begin
      send_idle_pct = (m == 0) ? 6 : (m == 1) ? 65 : 0;
      recv_idle_pct = (m == 0) ? 65 : (m == 1) ? 6 : 0;
      counted = 0;
      pressed = 1'b0;
      while (counted < 260) begin
        random_config();
        random_block(40, counted);
        if (!pressed) begin
          // sender holds off until all scores are out
          while (item_queue.size() > 10) @(posedge clk);
          hold_off = 1'b1;
          while (expected_scores.size() > 0) @(posedge clk);
          hold_off = 1'b0;
          pressed = 1'b1;
        end
      end
    end

    wait_idle();
    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1_000_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
